// File: rtl/assert_macros.svh
// assertion macros shared by the integrator rtl
// no dependencies; assertions are compiled out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PBE_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define PBE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PBE_ASSERT(lbl, clk, rst, prop, msg)
`define PBE_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// File: rtl/pbe_pkg.sv
// shared types, codes and saturating q16.16 helpers for the integrator
// no dependencies
package pbe_pkg;

  localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
  localparam logic [31:0] Q_ONE = 32'h0001_0000;

  // command codes
  localparam logic [2:0] CMD_FORCE    = 3'd0;
  localparam logic [2:0] CMD_TICK     = 3'd1;
  localparam logic [2:0] CMD_SEEK     = 3'd2;
  localparam logic [2:0] CMD_LOAD_POS = 3'd3;
  localparam logic [2:0] CMD_LOAD_VEL = 3'd4;

  // register indexes
  localparam logic [1:0] REG_MASS  = 2'd0;
  localparam logic [1:0] REG_SPEED = 2'd1;
  localparam logic [1:0] REG_STEER = 2'd2;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD_TMP, OP_MUL_FM, OP_ACC_ADD, OP_DIV_ACC, OP_ACCEL_FIN,
    OP_MUL_TD, OP_VEL_ADD, OP_MUL_VD, OP_POS_ADD, OP_DIFF_POS, OP_SQ, OP_SUM,
    OP_SQRT, OP_MUL_ML, OP_DIV_LIM, OP_LIM_FIN, OP_SUB_VEL, OP_LOAD_POS,
    OP_LOAD_VEL, OP_LD_OUT
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] axis;
    logic       lim_sel;
    logic       cap_in;
  } ctl_t;

  typedef struct packed {
    logic       div_busy;
    logic       sqrt_busy;
    logic       over;
    logic       out_free;
    logic [2:0] cmd;
  } stat_t;

  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    if (v > 33'sd2147483647) return Q_MAX;
    else if (v < -33'sd2147483648) return Q_MIN;
    else return v[31:0];
  endfunction

  function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    return sat33($signed({a[31], a}) + $signed({b[31], b}));
  endfunction

  function automatic logic signed [31:0] sub_sat(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    return sat33($signed({a[31], a}) - $signed({b[31], b}));
  endfunction

  // floor shift by 16 of a full product, then saturate
  function automatic logic signed [31:0] sat_prod(input logic signed [65:0] p);
    logic signed [65:0] s;
    s = p >>> 16;
    if (s > 66'sd2147483647) return Q_MAX;
    else if (s < -66'sd2147483648) return Q_MIN;
    else return s[31:0];
  endfunction

endpackage

// File: rtl/pbe_div.sv
// restoring divider, one quotient bit per cycle, 64-bit dividend
// depends on nothing
module pbe_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        busy,
  output logic [63:0] quo
);
  logic [31:0] rem;
  logic [31:0] d;
  logic [5:0]  cnt;
  logic [32:0] rem_sh;
  logic [32:0] rem_sub;
  logic        ge;

  assign rem_sh  = {rem, quo[63]};
  assign ge      = rem_sh >= {1'b0, d};
  assign rem_sub = rem_sh - {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
      quo  <= dividend;
      rem  <= '0;
      d    <= divisor;
    end else if (busy) begin
      rem <= ge ? rem_sub[31:0] : rem_sh[31:0];
      quo <= {quo[62:0], ge};
      cnt <= cnt + 6'd1;
      if (cnt == 6'd63) busy <= 1'b0;
    end
  end
endmodule

// File: rtl/pbe_sqrt.sv
// integer square root of a 64-bit value, one result bit per cycle
// depends on nothing
module pbe_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] val,
  output logic        busy,
  output logic [31:0] root
);
  logic [63:0] v;
  logic [63:0] r;
  logic [63:0] b;
  logic [4:0]  cnt;
  logic [63:0] t;

  assign t    = r + b;
  assign root = r[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
      v    <= val;
      r    <= '0;
      b    <= 64'h4000_0000_0000_0000;
    end else if (busy) begin
      if (v >= t) begin
        v <= v - t;
        r <= (r >> 1) + b;
      end else begin
        r <= r >> 1;
      end
      b   <= b >> 2;
      cnt <= cnt + 5'd1;
      if (cnt == 5'd31) busy <= 1'b0;
    end
  end
endmodule

// File: rtl/pbe_dp.sv
// datapath: body state, config registers, shared multiplier, divider and root unit
// depends on pbe_pkg, pbe_div, pbe_sqrt
module pbe_dp
  import pbe_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  ctl_t          ctl,
  output stat_t         stat,
  input  logic [119:0]  s_tdata,
  input  logic [7:0]    s_tuser,
  input  logic          cfg_valid,
  input  logic [1:0]    cfg_index,
  input  logic [31:0]   cfg_data,
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [191:0]  m_tdata
);
  logic signed [31:0] pos [3];
  logic signed [31:0] vel [3];
  logic signed [31:0] acc [3];
  logic signed [31:0] tmp [3];
  logic signed [31:0] vec [3];
  logic [16:0]        dt;
  logic [2:0]         cmd;
  logic [31:0]        mass, speed, steer;

  logic signed [65:0] prod;
  logic [63:0]        sum;
  logic               dneg;

  logic signed [32:0] mul_a, mul_b;
  logic signed [32:0] tabs;
  logic [31:0]        lim;
  logic [1:0]         ax;
  logic signed [31:0] accel;
  logic               div_start, sqrt_start;
  logic [63:0]        div_dividend;
  logic [31:0]        div_divisor;
  logic [63:0]        quo;
  logic [31:0]        len;
  logic               div_busy, sqrt_busy;

  assign ax  = ctl.axis;
  assign lim = ctl.lim_sel ? steer : speed;
  assign tabs = tmp[ax][31] ? -$signed({tmp[ax][31], tmp[ax]})
                            : $signed({tmp[ax][31], tmp[ax]});

  // multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctl.op)
      OP_MUL_FM: begin
        mul_a = {tmp[ax][31], tmp[ax]};
        mul_b = {1'b0, mass};
      end
      OP_MUL_TD: begin
        mul_a = {tmp[ax][31], tmp[ax]};
        mul_b = {16'b0, dt};
      end
      OP_MUL_VD: begin
        mul_a = {vel[ax][31], vel[ax]};
        mul_b = {16'b0, dt};
      end
      OP_SQ: begin
        mul_a = {tmp[ax][31], tmp[ax]};
        mul_b = {tmp[ax][31], tmp[ax]};
      end
      OP_MUL_ML: begin
        mul_a = tabs;
        mul_b = {1'b0, lim};
      end
      default: ;
    endcase
  end

  // divider feeds
  assign div_start    = (ctl.op == OP_DIV_ACC) || (ctl.op == OP_DIV_LIM);
  assign div_dividend = (ctl.op == OP_DIV_ACC)
                      ? {15'b0, (acc[ax][31] ? -$signed({acc[ax][31], acc[ax]})
                                             : $signed({acc[ax][31], acc[ax]})), 16'b0}
                      : prod[63:0];
  assign div_divisor  = (ctl.op == OP_DIV_ACC) ? mass : len;
  assign sqrt_start   = ctl.op == OP_SQRT;

  // acceleration from quotient, zero mass saturates by sign
  always_comb begin
    if (mass == '0) begin
      if (acc[ax] > 0) accel = Q_MAX;
      else if (acc[ax] < 0) accel = Q_MIN;
      else accel = '0;
    end else if (dneg) begin
      accel = (quo > 64'd2147483648) ? Q_MIN : $signed(32'd0 - quo[31:0]);
    end else begin
      accel = (quo > 64'd2147483647) ? Q_MAX : $signed(quo[31:0]);
    end
  end

  pbe_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quo      (quo)
  );

  pbe_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sqrt_start),
    .val   (sum),
    .busy  (sqrt_busy),
    .root  (len)
  );

  assign stat.div_busy  = div_busy;
  assign stat.sqrt_busy = sqrt_busy;
  assign stat.over      = len > lim;
  assign stat.out_free  = !m_tvalid || m_tready;
  assign stat.cmd       = cmd;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mass  <= Q_ONE;
      speed <= Q_ONE;
      steer <= Q_ONE;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MASS:  mass  <= cfg_data;
        REG_SPEED: speed <= cfg_data;
        REG_STEER: steer <= cfg_data;
        default: ;
      endcase
    end
  end

  // captured request and working registers
  always_ff @(posedge clk) begin
    if (ctl.cap_in) begin
      vec[0] <= s_tdata[31:0];
      vec[1] <= s_tdata[63:32];
      vec[2] <= s_tdata[95:64];
      dt     <= s_tdata[112:96];
      cmd    <= s_tuser[2:0];
    end
    case (ctl.op)
      OP_MUL_FM, OP_MUL_TD, OP_MUL_VD, OP_SQ, OP_MUL_ML: prod <= mul_a * mul_b;
      default: ;
    endcase
    if (ctl.op == OP_SUM) sum <= ((ax == 2'd0) ? 64'd0 : sum) + prod[63:0];
    if (ctl.op == OP_DIV_ACC) dneg <= acc[ax][31];
    case (ctl.op)
      OP_LOAD_TMP: tmp <= vec;
      OP_ACCEL_FIN: tmp[ax] <= accel;
      OP_DIFF_POS: for (int i = 0; i < 3; i++) tmp[i] <= sub_sat(vec[i], pos[i]);
      OP_SUB_VEL:  for (int i = 0; i < 3; i++) tmp[i] <= sub_sat(tmp[i], vel[i]);
      OP_LIM_FIN:  tmp[ax] <= tmp[ax][31] ? $signed(32'd0 - quo[31:0])
                                          : $signed(quo[31:0]);
      default: ;
    endcase
  end

  // body state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        pos[i] <= '0;
        vel[i] <= '0;
        acc[i] <= '0;
      end
    end else begin
      case (ctl.op)
        OP_ACC_ADD: acc[ax] <= add_sat(acc[ax], sat_prod(prod));
        OP_VEL_ADD: vel[ax] <= add_sat(vel[ax], sat_prod(prod));
        OP_POS_ADD: begin
          pos[ax] <= add_sat(pos[ax], sat_prod(prod));
          acc[ax] <= '0;
        end
        OP_LOAD_POS: pos <= vec;
        OP_LOAD_VEL: vel <= vec;
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctl.op == OP_LD_OUT) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (ctl.op == OP_LD_OUT) begin
      m_tdata <= {vel[2], vel[1], vel[0], pos[2], pos[1], pos[0]};
    end
  end
endmodule

// File: rtl/pbe_ctrl.sv
// controller: sequences one request through the datapath, axis by axis
// depends on pbe_pkg and assert_macros.svh
`include "assert_macros.svh"
module pbe_ctrl
  import pbe_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  s_tvalid,
  output logic  s_tready,
  input  stat_t stat,
  output ctl_t  ctl
);
  typedef enum logic [4:0] {
    ST_IDLE, ST_DISPATCH, ST_F_TMP, ST_F_MUL, ST_F_ADD,
    ST_T_DIV, ST_T_WAIT, ST_T_FIN, ST_T_MULA, ST_T_VADD, ST_T_MULV, ST_T_PADD,
    ST_S_DIFF, ST_S_SUBV, ST_L_SQ, ST_L_SUM, ST_L_SQRT, ST_L_SWAIT, ST_L_CHK,
    ST_L_MUL, ST_L_DIV, ST_L_DWAIT, ST_L_FIN, ST_L_END,
    ST_LD_POS, ST_LD_VEL, ST_DONE
  } state_t;

  state_t     state;
  logic [1:0] axis;
  logic       lim_sel;
  logic       last;

  assign last     = axis == 2'd2;
  assign s_tready = state == ST_IDLE;

  always_comb begin
    ctl.axis    = axis;
    ctl.lim_sel = lim_sel;
    ctl.cap_in  = (state == ST_IDLE) && s_tvalid;
    case (state)
      ST_F_TMP:  ctl.op = OP_LOAD_TMP;
      ST_F_MUL:  ctl.op = OP_MUL_FM;
      ST_F_ADD:  ctl.op = OP_ACC_ADD;
      ST_T_DIV:  ctl.op = OP_DIV_ACC;
      ST_T_FIN:  ctl.op = OP_ACCEL_FIN;
      ST_T_MULA: ctl.op = OP_MUL_TD;
      ST_T_VADD: ctl.op = OP_VEL_ADD;
      ST_T_MULV: ctl.op = OP_MUL_VD;
      ST_T_PADD: ctl.op = OP_POS_ADD;
      ST_S_DIFF: ctl.op = OP_DIFF_POS;
      ST_S_SUBV: ctl.op = OP_SUB_VEL;
      ST_L_SQ:   ctl.op = OP_SQ;
      ST_L_SUM:  ctl.op = OP_SUM;
      ST_L_SQRT: ctl.op = OP_SQRT;
      ST_L_MUL:  ctl.op = OP_MUL_ML;
      ST_L_DIV:  ctl.op = OP_DIV_LIM;
      ST_L_FIN:  ctl.op = OP_LIM_FIN;
      ST_LD_POS: ctl.op = OP_LOAD_POS;
      ST_LD_VEL: ctl.op = OP_LOAD_VEL;
      ST_DONE:   ctl.op = stat.out_free ? OP_LD_OUT : OP_NONE;
      default:   ctl.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      axis    <= '0;
      lim_sel <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          axis    <= '0;
          lim_sel <= 1'b0;
          if (s_tvalid) state <= ST_DISPATCH;
        end
        ST_DISPATCH: begin
          case (stat.cmd)
            CMD_FORCE:    state <= ST_F_TMP;
            CMD_TICK:     state <= ST_T_DIV;
            CMD_SEEK:     state <= ST_S_DIFF;
            CMD_LOAD_POS: state <= ST_LD_POS;
            CMD_LOAD_VEL: state <= ST_LD_VEL;
            default:      state <= ST_DONE;
          endcase
        end
        ST_F_TMP: state <= ST_F_MUL;
        ST_F_MUL: state <= ST_F_ADD;
        ST_F_ADD: begin
          axis  <= last ? 2'd0 : axis + 2'd1;
          state <= last ? ST_DONE : ST_F_MUL;
        end
        ST_T_DIV:  state <= ST_T_WAIT;
        ST_T_WAIT: if (!stat.div_busy) state <= ST_T_FIN;
        ST_T_FIN:  state <= ST_T_MULA;
        ST_T_MULA: state <= ST_T_VADD;
        ST_T_VADD: state <= ST_T_MULV;
        ST_T_MULV: state <= ST_T_PADD;
        ST_T_PADD: begin
          axis  <= last ? 2'd0 : axis + 2'd1;
          state <= last ? ST_DONE : ST_T_DIV;
        end
        ST_S_DIFF: state <= ST_L_SQ;
        ST_S_SUBV: state <= ST_L_SQ;
        ST_L_SQ:   state <= ST_L_SUM;
        ST_L_SUM: begin
          axis  <= last ? 2'd0 : axis + 2'd1;
          state <= last ? ST_L_SQRT : ST_L_SQ;
        end
        ST_L_SQRT:  state <= ST_L_SWAIT;
        ST_L_SWAIT: if (!stat.sqrt_busy) state <= ST_L_CHK;
        ST_L_CHK:   state <= stat.over ? ST_L_MUL : ST_L_END;
        ST_L_MUL:   state <= ST_L_DIV;
        ST_L_DIV:   state <= ST_L_DWAIT;
        ST_L_DWAIT: if (!stat.div_busy) state <= ST_L_FIN;
        ST_L_FIN: begin
          axis  <= last ? 2'd0 : axis + 2'd1;
          state <= last ? ST_L_END : ST_L_MUL;
        end
        ST_L_END: begin
          axis <= '0;
          if (!lim_sel) begin
            lim_sel <= 1'b1;
            state   <= ST_S_SUBV;
          end else begin
            state <= ST_F_MUL;
          end
        end
        ST_LD_POS: state <= ST_DONE;
        ST_LD_VEL: state <= ST_DONE;
        ST_DONE:   if (stat.out_free) state <= ST_IDLE;
        default:   state <= ST_IDLE;
      endcase
    end
  end

  `PBE_ASSERT(a_div_idle, clk, rst, (ctl.op == OP_DIV_ACC || ctl.op == OP_DIV_LIM) |-> !stat.div_busy, "divider started while busy")
  `PBE_ASSERT(a_sqrt_idle, clk, rst, (ctl.op == OP_SQRT) |-> !stat.sqrt_busy, "root unit started while busy")
  `PBE_ASSERT(a_out_free, clk, rst, (ctl.op == OP_LD_OUT) |-> stat.out_free, "result overwritten")
  `PBE_ASSERT(a_axis, clk, rst, axis != 2'd3, "axis out of range")
  `PBE_ASSERT_ALWAYS(a_rst_idle, clk, rst |=> (state == ST_IDLE && !lim_sel), "not idle after reset")
endmodule

// File: rtl/point_body_euler_seek_integrator_core.sv
// point-body integrator; commands: loads, apply force, tick (one 64-step division per
// axis) and seek (two 32-step roots, up to six 64-step divisions), unused codes just
// return a result; one request in flight, the next one taken the cycle after its result
// is loaded; a finished result waits in the output register while the next request is
// worked, which stalls only at its result
// synchronous active-high reset: position, velocity, force zero; mass and limits 1.0
module point_body_euler_seek_integrator_core
  import pbe_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  // request channel
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [119:0] s_tdata,  // vec_x, vec_y, vec_z, time_step, zero pad
  input  logic [7:0]   s_tuser,  // cmd, zero pad
  // result channel
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [191:0] m_tdata,  // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z
  // register writes: 0 body_mass, 1 speed_limit, 2 steer_limit
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);
  ctl_t  ctl;
  stat_t stat;

  // the user must write registers only while idle; the block itself does not enforce it, so always take writes
  assign cfg_ready = 1'b1;

  pbe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .ctl      (ctl)
  );

  pbe_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .stat      (stat),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );
endmodule
